// File: rtl/core/ptt_pkg.sv
package ptt_pkg;

  localparam int TIMER_SLOTS_DEF = 16;

  localparam logic [31:0] SECS_PER_HOUR = 32'd3600;
  localparam logic [31:0] SECS_PER_MIN  = 32'd60;
  localparam logic [31:0] SECS_PER_DAY  = 32'd86400;

  typedef enum logic [1:0] {
    OP_ADD_DAILY = 2'd0,
    OP_ADD_PER   = 2'd1,
    OP_DELETE    = 2'd2,
    OP_TICK      = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_DONE     = 2'd0,
    KIND_FIRED    = 2'd1,
    KIND_FULL     = 2'd2,
    KIND_NOTFOUND = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_FIND = 2'd1,
    ST_SCAN = 2'd2,
    ST_FIN  = 2'd3
  } state_t;

  // classified command passed front to back
  typedef struct packed {
    opcode_t     op;
    logic [31:0] ident;
    logic [31:0] data;
    logic [21:0] offset;
    logic [31:0] base;
    logic [31:0] now;
  } cmd_t;

endpackage

// File: rtl/core/ptt_front.sv
module ptt_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_opcode,
  input  logic [31:0]      in_timer_id,
  input  logic [31:0]      in_user_data,
  input  logic [9:0]       in_hours,
  input  logic [5:0]       in_minutes,
  input  logic [5:0]       in_seconds,
  input  logic [31:0]      in_now_time,
  input  logic [31:0]      in_day_start,
  output logic             cmd_valid,
  input  logic             cmd_stall,
  output ptt_pkg::cmd_t    cmd
);

  // stage 1: products registered; stage 2: sum and base
  logic             s1_valid_r;
  logic [1:0]       s1_op_r;
  logic [31:0]      s1_id_r, s1_data_r, s1_now_r, s1_base_r;
  logic [21:0]      s1_h_r;
  logic [11:0]      s1_m_r;
  logic [5:0]       s1_s_r;
  logic             s2_valid_r;
  ptt_pkg::cmd_t    s2_r;
  logic             s2_free, s1_free;
  logic [21:0]      off;

  assign s2_free  = !s2_valid_r || !cmd_stall;
  assign s1_free  = !s1_valid_r || s2_free;
  assign in_stall = !s1_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_free) begin
      s1_valid_r <= in_valid;
    end
    if (s1_free && in_valid) begin
      s1_op_r   <= in_opcode;
      s1_id_r   <= in_timer_id;
      s1_data_r <= in_user_data;
      s1_now_r  <= in_now_time;
      s1_base_r <= (in_opcode == ptt_pkg::OP_ADD_DAILY) ? in_day_start : in_now_time;
      s1_h_r    <= 22'(in_hours) * 22'd3600;
      s1_m_r    <= 12'(in_minutes) * 12'd60;
      s1_s_r    <= in_seconds;
    end
  end

  assign off = s1_h_r + 22'(s1_m_r) + 22'(s1_s_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_free) begin
      s2_valid_r <= s1_valid_r;
    end
    if (s2_free && s1_valid_r) begin
      s2_r.op     <= ptt_pkg::opcode_t'(s1_op_r);
      s2_r.ident  <= s1_id_r;
      s2_r.data   <= s1_data_r;
      s2_r.offset <= off;
      s2_r.base   <= s1_base_r + 32'(off);
      s2_r.now    <= s1_now_r;
    end
  end

  assign cmd_valid = s2_valid_r;
  assign cmd       = s2_r;

endmodule

// File: rtl/core/ptt_back.sv
module ptt_back #(
  parameter int TIMER_SLOTS = ptt_pkg::TIMER_SLOTS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cmd_valid,
  output logic             cmd_stall,
  input  ptt_pkg::cmd_t    cmd,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       out_result_kind,
  output logic [31:0]      out_fired_id,
  output logic [31:0]      out_fired_data,
  output logic             out_last
);

  localparam int IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int CW = $clog2(TIMER_SLOTS + 1);

  logic [TIMER_SLOTS-1:0] valid_r, valid_nxt;
  logic [31:0]            ident_r [TIMER_SLOTS];
  logic [31:0]            data_r  [TIMER_SLOTS];
  logic [31:0]            due_r   [TIMER_SLOTS];
  logic [21:0]            per_r   [TIMER_SLOTS];
  logic [TIMER_SLOTS-1:0] daily_r;

  ptt_pkg::state_t state_r, state_nxt;
  ptt_pkg::cmd_t   c_r;
  logic [CW-1:0]   idx_r, idx_nxt;
  logic [1:0]      fin_kind_r, fin_kind_nxt;
  logic            take, ld, wr_add, wr_due, emit_fire, emit_fin;
  logic [IW-1:0]   ix;

  logic            ov_r;
  logic [1:0]      okind_r;
  logic [31:0]     oid_r, odata_r;
  logic            olast_r;
  logic            ofree;

  assign ofree     = !ov_r || !out_stall;
  assign ix        = idx_r[IW-1:0];
  assign cmd_stall = (state_r != ptt_pkg::ST_IDLE);
  assign take      = cmd_valid && !cmd_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ptt_pkg::ST_IDLE;
      valid_r <= '0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
    idx_r      <= idx_nxt;
    fin_kind_r <= fin_kind_nxt;
    if (take) c_r <= cmd;
    if (wr_add) begin
      ident_r[ix] <= c_r.ident;
      data_r[ix]  <= c_r.data;
      per_r[ix]   <= c_r.offset;
      due_r[ix]   <= c_r.base;
      daily_r[ix] <= (c_r.op == ptt_pkg::OP_ADD_DAILY);
    end else if (wr_due) begin
      due_r[ix] <= due_r[ix] + (daily_r[ix] ? ptt_pkg::SECS_PER_DAY : 32'(per_r[ix]));
    end
  end

  // one slot per cycle, a firing slot waiting while the output stalls: find-free / find-match / tick scan
  always_comb begin
    state_nxt    = state_r;
    valid_nxt    = valid_r;
    idx_nxt      = idx_r;
    fin_kind_nxt = fin_kind_r;
    wr_add       = 1'b0;
    wr_due       = 1'b0;
    emit_fire    = 1'b0;
    emit_fin     = 1'b0;
    case (state_r)
      ptt_pkg::ST_IDLE: begin
        idx_nxt = '0;
        if (take) state_nxt = (cmd.op == ptt_pkg::OP_TICK) ? ptt_pkg::ST_SCAN
                                                           : ptt_pkg::ST_FIND;
      end
      ptt_pkg::ST_FIND: begin
        if (idx_r == CW'(TIMER_SLOTS)) begin
          fin_kind_nxt = (c_r.op == ptt_pkg::OP_DELETE) ? ptt_pkg::KIND_NOTFOUND
                                                        : ptt_pkg::KIND_FULL;
          state_nxt = ptt_pkg::ST_FIN;
        end else if (c_r.op == ptt_pkg::OP_DELETE) begin
          if (valid_r[ix] && ident_r[ix] == c_r.ident) begin
            valid_nxt[ix] = 1'b0;
            fin_kind_nxt  = ptt_pkg::KIND_DONE;
            state_nxt     = ptt_pkg::ST_FIN;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end else if (!valid_r[ix]) begin
          valid_nxt[ix] = 1'b1;
          wr_add        = 1'b1;
          fin_kind_nxt  = ptt_pkg::KIND_DONE;
          state_nxt     = ptt_pkg::ST_FIN;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ptt_pkg::ST_SCAN: begin
        if (idx_r == CW'(TIMER_SLOTS)) begin
          fin_kind_nxt = ptt_pkg::KIND_DONE;
          state_nxt    = ptt_pkg::ST_FIN;
        end else if (valid_r[ix] && c_r.now >= due_r[ix]) begin
          if (ofree) begin
            emit_fire = 1'b1;
            wr_due    = 1'b1;
            idx_nxt   = idx_r + 1'b1;
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ptt_pkg::ST_FIN: begin
        if (ofree) begin
          emit_fin  = 1'b1;
          state_nxt = ptt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ptt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (ofree) begin
      ov_r <= emit_fire || emit_fin;
    end
    if (emit_fire) begin
      okind_r <= ptt_pkg::KIND_FIRED;
      oid_r   <= ident_r[ix];
      odata_r <= data_r[ix];
      olast_r <= 1'b0;
    end else if (emit_fin) begin
      okind_r <= fin_kind_r;
      oid_r   <= '0;
      odata_r <= '0;
      olast_r <= 1'b1;
    end
  end

  assign out_valid       = ov_r;
  assign out_result_kind = okind_r;
  assign out_fired_id    = oid_r;
  assign out_fired_data  = odata_r;
  assign out_last        = olast_r;

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= CW'(TIMER_SLOTS)) else $error("slot index overrun");
  a_fire_scan: assert property (@(posedge clk) disable iff (!rst_n)
    emit_fire |-> state_r == ptt_pkg::ST_SCAN) else $error("fire outside scan");
  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> state_r != ptt_pkg::ST_IDLE) else $error("command lost");
  a_add_free: assert property (@(posedge clk) disable iff (!rst_n)
    wr_add |-> !valid_r[ix]) else $error("add over live slot");

endmodule

// File: rtl/core/periodic_timer_table.sv
// Results: a fired result leaves as the table walk reaches its slot; an add or delete
// result after the slot it stops at; full, not-found and tick-done after a full walk.
// Throughput: the back takes one item at a time and walks the table one slot a cycle;
// fired results stream one a cycle while out_stall is low, and a stall holds the walk.
// The two-stage front takes new items while the back walks the table, until it fills.
// Reset: synchronous active-low rst_n clears all slots to invalid and empties the pipe.
module periodic_timer_table #(
  parameter int TIMER_SLOTS = ptt_pkg::TIMER_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [31:0] in_timer_id,
  input  logic [31:0] in_user_data,
  input  logic [9:0]  in_hours,
  input  logic [5:0]  in_minutes,
  input  logic [5:0]  in_seconds,
  input  logic [31:0] in_now_time,
  input  logic [31:0] in_day_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_result_kind,
  output logic [31:0] out_fired_id,
  output logic [31:0] out_fired_data,
  output logic        out_last
);

  logic          cmd_valid, cmd_stall;
  ptt_pkg::cmd_t cmd;

  ptt_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_opcode, .in_timer_id, .in_user_data,
    .in_hours, .in_minutes, .in_seconds, .in_now_time, .in_day_start,
    .cmd_valid, .cmd_stall, .cmd
  );

  ptt_back #(.TIMER_SLOTS(TIMER_SLOTS)) u_back (
    .clk, .rst_n, .cmd_valid, .cmd_stall, .cmd,
    .out_valid, .out_stall, .out_result_kind, .out_fired_id, .out_fired_data, .out_last
  );

endmodule
